// File: sv/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types, operation codes and sizing constants of the huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_SYMBOL_COUNT = 256;

	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int BYTE_W = 8;
	localparam int OP_W   = 2;
	localparam int BUF_W  = BYTE_W + CODE_W;

	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
	} result_t;

endpackage

// File: sv/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/huffman_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// First byte of an item: table read register, then byte emitter register.
// Throughput: one item per cycle while each item gives at most one byte and
// the receiver does not stall; an encode that gives n bytes holds the emitter
// until they are taken, one byte a cycle while the receiver does not stall.
// Reset clears the pipeline, the emitter and the pending partial byte; the
// code table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top #(
	parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  hcbp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output hcbp_pkg::result_t result
);

	import hcbp_pkg::*;

	localparam int AW      = $clog2(SYMBOL_COUNT);
	localparam int ENTRY_W = CODE_W + LEN_W;
	localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W+1)'(SYMBOL_COUNT);
	localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
	localparam logic [LEN_W-1:0] CODE_W_V  = LEN_W'(CODE_W);

	logic item_accept;
	logic result_accept;
	logic item_hit;
	logic s1_ready;
	logic emit_take;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic              hit_s1;

	logic [BYTE_W-1:0] pending_byte_q;
	logic [2:0]        pending_count_q;
	logic [BUF_W-1:0]  emit_buf_q;
	logic [2:0]        emit_left_q;

	logic               ram_we;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [LEN_W-1:0]   load_len;

	logic [CODE_W-1:0] rd_code;
	logic [LEN_W-1:0]  rd_len;
	logic [LEN_W-1:0]  clen;
	logic [CODE_W-1:0] code_al;
	logic [BUF_W-1:0]  enc_buf;
	logic [BUF_W-1:0]  enc_shift;
	logic [LEN_W-1:0]  total;
	logic [2:0]        nbytes;

	assign item_hit      = {1'b0, item.symbol} < SYM_LIMIT;
	assign emit_take     = (emit_left_q == 3'd0) || ((emit_left_q == 3'd1) && !result_stall);
	assign s1_ready      = !valid_s1 || emit_take;
	assign item_stall    = !s1_ready;
	assign item_accept   = item_valid && s1_ready;
	assign result_valid  = emit_left_q != 3'd0;
	assign result_accept = result_valid && !result_stall;

	assign result.out_byte    = emit_buf_q[BUF_W-1 -: BYTE_W];
	assign result.last_of_run = emit_left_q == 3'd1;

	// table write on load of an in-range symbol, table read on every item
	assign load_len  = (item.code_length > LEN_CAP_V) ? LEN_CAP_V : item.code_length;
	assign ram_we    = item_accept && (item.operation == OP_LOAD) && item_hit;
	assign ram_wdata = {item.code_word, load_len};

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SYMBOL_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.re   (item_accept),
		.addr (item.symbol[AW-1:0]),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// merge the code behind the pending bits, left aligned
	always_comb begin
		rd_code   = ram_rdata[ENTRY_W-1 -: CODE_W];
		rd_len    = ram_rdata[LEN_W-1:0];
		clen      = (rd_len > CODE_W_V) ? CODE_W_V : rd_len;
		code_al   = rd_code << (CODE_W_V - clen);
		enc_buf   = {pending_byte_q, {CODE_W{1'b0}}} | ({code_al, {BYTE_W{1'b0}}} >> pending_count_q);
		total     = {3'b000, pending_count_q} + clen;
		nbytes    = total[5:3];
		enc_shift = enc_buf << {nbytes, 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= item_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_s1  <= item.operation;
			hit_s1 <= item_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_byte_q  <= '0;
			pending_count_q <= '0;
			emit_left_q     <= '0;
		end else begin
			if (result_accept) begin
				emit_left_q <= emit_left_q - 3'd1;
			end
			if (valid_s1 && emit_take) begin
				if (op_s1 == OP_ENCODE && hit_s1) begin
					pending_byte_q  <= enc_shift[BUF_W-1 -: BYTE_W];
					pending_count_q <= total[2:0];
					emit_left_q     <= nbytes;
				end else if (op_s1 == OP_FLUSH && pending_count_q != 3'd0) begin
					pending_byte_q  <= '0;
					pending_count_q <= '0;
					emit_left_q     <= 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && emit_take && op_s1 == OP_ENCODE && hit_s1) begin
			emit_buf_q <= enc_buf;
		end else if (valid_s1 && emit_take && op_s1 == OP_FLUSH) begin
			emit_buf_q <= {pending_byte_q, {CODE_W{1'b0}}};
		end else if (result_accept) begin
			emit_buf_q <= emit_buf_q << BYTE_W;
		end
	end

`ifndef ASSERT_OFF
	a_emit_max: assert property (@(posedge clk) disable iff (!arst_n)
		emit_left_q <= 3'd4)
		else $error("emitter holds more than four bytes");

	a_pending_clean: assert property (@(posedge clk) disable iff (!arst_n)
		((8'hFF >> pending_count_q) & pending_byte_q) == 8'd0)
		else $error("pending byte has bits below its count");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !emit_take |=> valid_s1 && $stable(op_s1) && $stable(hit_s1))
		else $error("stage one lost a held item");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !emit_take |-> !ram_we)
		else $error("table written while stage one is held");
`endif

endmodule

// File: test/huffman_code_bit_packer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top_tb
// Self-checking bench for the huffman code bit packer. Loads code table
// entries, encodes symbols and flushes the partial byte. A local packer
// model predicts every output byte, and each result word is checked in
// order. Directed edge cases come first, then random traffic under several
// sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top_tb;
	import hcbp_pkg::*;

	localparam int SYM_COUNT    = DEF_SYMBOL_COUNT;
	localparam int CODE_LEN_MAX = DEF_MAX_CODE_LEN;
	localparam int STALL_LIMIT  = 5000;
	localparam int PHASE_WORDS  = 95;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   in_word;
	logic    result_valid;
	logic    result_stall;
	result_t out_word;

	huffman_code_bit_packer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (in_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (out_word)
	);

	// packer model state
	logic [CODE_W-1:0] code_mem [SYM_COUNT];
	logic [LEN_W-1:0]  len_mem  [SYM_COUNT];
	bit                written  [SYM_COUNT];
	logic [SYM_W-1:0]  written_syms [$];
	logic [7:0]        part_byte;
	int unsigned       part_bits;
	result_t           byte_q [$];

	int send_idle_pct;
	int stall_pct;
	int errors;
	int idle_cycles;
	int n_loads;
	int n_encodes;
	int n_flushes;
	int n_bytes;
	result_t want;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void pack_word(item_t w);
		logic [63:0] acc;
		int unsigned clen;
		int unsigned total;
		int unsigned nbytes;
		int unsigned rem;
		int unsigned sh;
		result_t r;
		case (w.operation)
			OP_LOAD: begin
				if (w.symbol < SYM_COUNT) begin
					clen = w.code_length;
					if (clen > CODE_LEN_MAX) clen = CODE_LEN_MAX;
					if (clen > CODE_W) clen = CODE_W;
					code_mem[w.symbol] = w.code_word;
					len_mem[w.symbol]  = clen[LEN_W-1:0];
					if (!written[w.symbol]) written_syms.push_back(w.symbol);
					written[w.symbol] = 1'b1;
				end
			end
			OP_ENCODE: begin
				if (w.symbol < SYM_COUNT) begin
					clen = len_mem[w.symbol];
					acc = (part_bits == 0) ? 64'd0 : 64'(part_byte >> (8 - part_bits));
					acc = (acc << clen) | (64'(code_mem[w.symbol]) & ((64'd1 << clen) - 1));
					total  = part_bits + clen;
					nbytes = total / 8;
					rem    = total % 8;
					for (int k = 0; k < nbytes; k++) begin
						sh = total - 8 * (k + 1);
						r.out_byte    = 8'(acc >> sh);
						r.last_of_run = (k + 1 == nbytes);
						byte_q.push_back(r);
					end
					part_byte = 8'((acc & ((64'd1 << rem) - 1)) << (8 - rem));
					part_bits = rem;
				end
			end
			OP_FLUSH: begin
				if (part_bits != 0) begin
					r.out_byte    = part_byte;
					r.last_of_run = 1'b1;
					byte_q.push_back(r);
					part_byte = '0;
					part_bits = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// called and returns at a falling edge
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		in_word    <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pack_word(w);
		case (w.operation)
			OP_LOAD:   n_loads++;
			OP_ENCODE: n_encodes++;
			OP_FLUSH:  n_flushes++;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		item_t w;
		w.operation   = op;
		w.symbol      = sym;
		w.code_word   = code;
		w.code_length = len;
		send_word(w);
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		while (byte_q.size() != 0) @(negedge clk);
	endtask

	// receiver back pressure
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (byte_q.size() == 0) begin
				$error("unexpected result word: out_byte %02h last_of_run %0d",
					out_word.out_byte, out_word.last_of_run);
				errors++;
			end else begin
				want = byte_q.pop_front();
				n_bytes++;
				if (out_word.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, out_word.out_byte);
					errors++;
				end
				if (out_word.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d",
						want.last_of_run, out_word.last_of_run);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d bytes outstanding",
					idle_cycles, byte_q.size());
				$display("** huffman_code_bit_packer_top: FAILED **");
				$finish;
			end
		end
	end

	task automatic test_table_load();
		send_op(OP_LOAD, 8'd0,   32'h0000_0001, 6'd1);
		send_op(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
		send_op(OP_LOAD, 8'd1,   32'h0000_DEAD, 6'd0);
		send_op(OP_LOAD, 8'd2,   32'hA5A5_A5A5, 6'd63);
		send_op(OP_LOAD, 8'd3,   32'h1234_5678, 6'd33);
		send_op(OP_LOAD, 8'd4,   32'h0000_0055, 6'd7);
		send_op(OP_LOAD, 8'd5,   32'h0000_00C3, 6'd8);
	endtask

	task automatic test_encode_lengths();
		send_op(OP_ENCODE, 8'd5,   $urandom, 6'(0));
		send_op(OP_ENCODE, 8'd0,   $urandom, 6'(63));
		send_op(OP_ENCODE, 8'd255, '0, '0);
		send_op(OP_ENCODE, 8'd4,   '0, '0);
		send_op(OP_ENCODE, 8'd1,   '0, '0);
		send_op(OP_ENCODE, 8'd2,   '0, '0);
		send_op(OP_ENCODE, 8'd0,   '0, '0);
		send_op(OP_ENCODE, 8'd3,   '0, '0);
	endtask

	task automatic test_flush_and_unused();
		send_op(OP_FLUSH,  8'd0,   '0, '0);
		send_op(OP_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'd63);
		send_op(OP_ENCODE, 8'd0,   '0, '0);
		send_op(OP_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
		send_op(OP_ENCODE, 8'd0,   '0, '0);
		send_op(OP_FLUSH,  8'd7,   '0, '0);
		wait_drain();
	endtask

	task automatic test_random_traffic();
		int pick;
		int lsel;
		logic [LEN_W-1:0] len;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 60; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 60; end
				default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase
			for (int i = 0; i < PHASE_WORDS; i++) begin
				pick = $urandom_range(99);
				if (pick < 12) begin
					lsel = $urandom_range(99);
					if (lsel < 5)       len = '0;
					else if (lsel < 12) len = 6'($urandom_range(63, 33));
					else if (lsel < 25) len = 6'($urandom_range(32, 17));
					else                len = 6'($urandom_range(16, 1));
					send_op(OP_LOAD, 8'($urandom_range(255)), $urandom, len);
				end else if (pick < 22) begin
					send_op(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
				end else if (pick < 24) begin
					send_op(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom));
				end else begin
					send_op(OP_ENCODE,
						written_syms[$urandom_range(written_syms.size() - 1)],
						$urandom, 6'($urandom));
				end
			end
			// no sender idling and no receiver stall for the closing flush and drain
			send_idle_pct = 0;
			stall_pct     = 0;
			send_op(OP_FLUSH, '0, '0, '0);
			wait_drain();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		in_word       = '0;
		result_stall  = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		errors        = 0;
		idle_cycles   = 0;
		n_loads       = 0;
		n_encodes     = 0;
		n_flushes     = 0;
		n_bytes       = 0;
		part_byte     = '0;
		part_bits     = 0;
		for (int s = 0; s < SYM_COUNT; s++) begin
			code_mem[s] = '0;
			len_mem[s]  = '0;
			written[s]  = 1'b0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_table_load();
		test_encode_lengths();
		test_flush_and_unused();
		test_random_traffic();

		wait_drain();
		repeat (10) @(negedge clk);
		$display("run covered %0d loads, %0d encodes, %0d flushes; %0d bytes checked",
			n_loads, n_encodes, n_flushes, n_bytes);
		$display("traffic mixes: free flow, sender idle, receiver stall, both; %0d errors",
			errors);
		if (errors == 0 && byte_q.size() == 0)
			$display("** huffman_code_bit_packer_top: PASSED **");
		else
			$display("** huffman_code_bit_packer_top: FAILED **");
		$finish;
	end

endmodule

// File: files.f
sv/hcbp_pkg.sv
sv/hcbp_ram.sv
sv/huffman_code_bit_packer_top.sv
test/huffman_code_bit_packer_top_tb.sv
